// File: rtl/core/great_circle_bearing_top_defines.svh
// Assertion helpers for the bearing block. Both sample on clk and are off while rst is high.
`ifndef GREAT_CIRCLE_BEARING_TOP_DEFINES_SVH
`define GREAT_CIRCLE_BEARING_TOP_DEFINES_SVH

// Same-cycle implication.
`define GCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GCB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/gcb_pkg.sv
package gcb_pkg;

  localparam int CORDIC_STEPS_DEF  = 24;
  localparam int OUT_FRAC_BITS_DEF = 16;

  localparam int ANG_FRAC = 30;
  localparam int CW       = 36;

  localparam logic signed [34:0] DEG_TURN    = 35'sd3600000000;
  localparam logic signed [34:0] DEG_HALF    = 35'sd1800000000;
  localparam logic signed [34:0] DEG_QUARTER = 35'sd900000000;
  localparam logic        [32:0] RAD_MUL     = 33'd8048910509;
  localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_INV    = 36'sd652032874;
  localparam logic signed [CW-1:0] BEAR_MAX    = 36'sd262143;

  localparam int BEAR_W = 19;

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  return 36'sd843314856;
      5'd1:  return 36'sd497837829;
      5'd2:  return 36'sd263043836;
      5'd3:  return 36'sd133525158;
      5'd4:  return 36'sd67021686;
      5'd5:  return 36'sd33543515;
      5'd6:  return 36'sd16775850;
      5'd7:  return 36'sd8388437;
      5'd8:  return 36'sd4194282;
      5'd9:  return 36'sd2097149;
      5'd10: return 36'sd1048575;
      5'd11: return 36'sd524287;
      5'd12: return 36'sd262143;
      5'd13: return 36'sd131071;
      5'd14: return 36'sd65535;
      5'd15: return 36'sd32767;
      5'd16: return 36'sd16383;
      5'd17: return 36'sd8191;
      5'd18: return 36'sd4095;
      5'd19: return 36'sd2047;
      5'd20: return 36'sd1023;
      5'd21: return 36'sd511;
      5'd22: return 36'sd255;
      5'd23: return 36'sd127;
      5'd24: return 36'sd63;
      5'd25: return 36'sd31;
      5'd26: return 36'sd15;
      5'd27: return 36'sd7;
      5'd28: return 36'sd3;
      5'd29: return 36'sd1;
      default: return '0;
    endcase
  endfunction

endpackage

// File: rtl/core/gcb_sincos.sv
module gcb_sincos #(
  parameter int STEPS = gcb_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] ang,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);

  localparam int CW = gcb_pkg::CW;

  logic signed [34:0] a_ext;
  logic signed [30:0] r1;
  logic               neg1;
  logic        [62:0] prod2;
  logic               sgn2;
  logic               neg2;
  logic        [63:0] rnd;

  logic signed [CW-1:0] x [0:STEPS];
  logic signed [CW-1:0] y [0:STEPS];
  logic signed [CW-1:0] z [0:STEPS];
  logic                 ng [0:STEPS];
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] xs;

  assign a_ext = 35'(ang);

  // quadrant fold
  always_ff @(posedge clk) begin
    if (en) begin
      if (a_ext > gcb_pkg::DEG_QUARTER) begin
        r1   <= 31'(a_ext - gcb_pkg::DEG_HALF);
        neg1 <= 1'b1;
      end else if (a_ext < -gcb_pkg::DEG_QUARTER) begin
        r1   <= 31'(a_ext + gcb_pkg::DEG_HALF);
        neg1 <= 1'b1;
      end else begin
        r1   <= 31'(a_ext);
        neg1 <= 1'b0;
      end
    end
  end

  // degree to radian, magnitude is unsigned
  always_ff @(posedge clk) begin
    if (en) begin
      prod2 <= 63'(30'($unsigned(r1[30] ? -r1 : r1))) * 63'(gcb_pkg::RAD_MUL);
      sgn2  <= r1[30];
      neg2  <= neg1;
    end
  end

  assign rnd = 64'(prod2) + 64'h8000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      z[0]  <= sgn2 ? -CW'(rnd[63:32]) : CW'(rnd[63:32]);
      x[0]  <= gcb_pkg::GAIN_INV;
      y[0]  <= '0;
      ng[0] <= neg2;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_stg
    always_ff @(posedge clk) begin
      if (en) begin
        ng[i+1] <= ng[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - gcb_pkg::atan_q30(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + gcb_pkg::atan_q30(5'(i));
        end
      end
    end
  end

  assign ys = ng[STEPS] ? -y[STEPS] : y[STEPS];
  assign xs = ng[STEPS] ? -x[STEPS] : x[STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= ys[31:0];
      cos_q <= xs[31:0];
    end
  end

endmodule

// File: rtl/core/gcb_atan2.sv
module gcb_atan2 #(
  parameter int STEPS         = gcb_pkg::CORDIC_STEPS_DEF,
  parameter int OUT_FRAC_BITS = gcb_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [32:0]                  num,
  input  logic signed [32:0]                  den,
  input  logic                                zero,
  output logic signed [gcb_pkg::BEAR_W-1:0]   bearing
);

  localparam int CW = gcb_pkg::CW;
  localparam int SH = gcb_pkg::ANG_FRAC - OUT_FRAC_BITS;

  logic signed [CW-1:0] nx, ny;
  logic signed [CW-1:0] x [0:STEPS];
  logic signed [CW-1:0] y [0:STEPS];
  logic signed [CW-1:0] z [0:STEPS];
  logic                 zf [0:STEPS];
  logic signed [CW-1:0] zc, zr, b;

  assign nx = CW'(den);
  assign ny = CW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= zero;
      if (nx < 0) begin
        if (ny >= 0) begin
          x[0] <= ny;
          y[0] <= -nx;
          z[0] <= gcb_pkg::HALF_PI_Q30;
        end else begin
          x[0] <= -ny;
          y[0] <= nx;
          z[0] <= -gcb_pkg::HALF_PI_Q30;
        end
      end else begin
        x[0] <= nx;
        y[0] <= ny;
        z[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_stg
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (y[i] >= 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + gcb_pkg::atan_q30(5'(i));
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - gcb_pkg::atan_q30(5'(i));
        end
      end
    end
  end

  always_comb begin
    zc = z[STEPS];
    if (zc > gcb_pkg::PI_Q30)  zc = gcb_pkg::PI_Q30;
    if (zc < -gcb_pkg::PI_Q30) zc = -gcb_pkg::PI_Q30;
    zr = zc + (CW'(1) <<< (SH - 1));
    b  = zr >>> SH;
    if (b > gcb_pkg::BEAR_MAX)  b = gcb_pkg::BEAR_MAX;
    if (b < -gcb_pkg::BEAR_MAX) b = -gcb_pkg::BEAR_MAX;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bearing <= zf[STEPS] ? '0 : b[gcb_pkg::BEAR_W-1:0];
    end
  end

endmodule

// File: rtl/core/great_circle_bearing_top.sv
// Pipeline: input register, sin/cos CORDIC chains, product and difference registers, atan2 CORDIC chain.
// Throughput: one position per cycle unless the output stalls; set by the unrolled sin/cos and atan2 CORDIC chains.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (rst, synchronous): clears valid bits and both target registers to 0.
module great_circle_bearing_top #(
  parameter int CORDIC_STEPS  = gcb_pkg::CORDIC_STEPS_DEF,
  parameter int OUT_FRAC_BITS = gcb_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // cur_lat[30:0], cur_lon[62:31], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // bearing[18:0], zero pad
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_data
);

  `include "great_circle_bearing_top_defines.svh"

  localparam int SC_LAT = CORDIC_STEPS + 4;
  localparam int AT_LAT = CORDIC_STEPS + 2;
  localparam int LAT    = 1 + SC_LAT + 3 + AT_LAT;

  localparam logic REG_LAT = 1'b0;
  localparam logic REG_LON = 1'b1;

  logic signed [30:0] target_lat;
  logic signed [31:0] target_lon;

  logic signed [30:0] cur_lat;
  logic signed [31:0] cur_lon;
  logic               en;
  logic               vld [0:LAT-1];

  logic signed [34:0] d;
  logic signed [34:0] dw;
  logic signed [31:0] lat1_q, lat2_q, dlon_q;
  logic               coin_q;
  logic               coin_d [0:SC_LAT-1];

  logic signed [31:0] s1, c1, s2, c2, sd, cd;
  logic signed [63:0] px, pa, pb;
  logic signed [31:0] x1, t1, tb, cd1;
  logic               z1;
  logic signed [63:0] pc;
  logic signed [31:0] x2, t2, t3;
  logic               z2;
  logic signed [32:0] x3, y3;
  logic               z3;
  logic signed [gcb_pkg::BEAR_W-1:0] bearing;

  assign cur_lat = s_tdata[30:0];
  assign cur_lon = s_tdata[62:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_lat <= '0;
      target_lon <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LAT: target_lat <= cfg_data[30:0];
        REG_LON: target_lon <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];
  assign m_tdata  = {5'b0, bearing};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k < LAT; k++) vld[k] <= vld[k-1];
    end
  end

  // longitude difference wrapped to (-180, 180] deg
  always_comb begin
    d  = 35'(target_lon) - 35'(cur_lon);
    dw = d;
    if (d > gcb_pkg::DEG_HALF)       dw = d - gcb_pkg::DEG_TURN;
    else if (d <= -gcb_pkg::DEG_HALF) dw = d + gcb_pkg::DEG_TURN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat1_q <= 32'(cur_lat);
      lat2_q <= 32'(target_lat);
      dlon_q <= dw[31:0];
      coin_q <= (dw == '0) && (cur_lat == target_lat);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coin_d[0] <= coin_q;
      for (int k = 1; k < SC_LAT; k++) coin_d[k] <= coin_d[k-1];
    end
  end

  gcb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat1 (
    .clk(clk), .en(en), .ang(lat1_q), .sin_q(s1), .cos_q(c1));
  gcb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat2 (
    .clk(clk), .en(en), .ang(lat2_q), .sin_q(s2), .cos_q(c2));
  gcb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dlon (
    .clk(clk), .en(en), .ang(dlon_q), .sin_q(sd), .cos_q(cd));

  assign px = 64'(c2) * 64'(sd);
  assign pa = 64'(c1) * 64'(s2);
  assign pb = 64'(s1) * 64'(c2);

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= px[61:30];
      t1  <= pa[61:30];
      tb  <= pb[61:30];
      cd1 <= cd;
      z1  <= coin_d[SC_LAT-1];
    end
  end

  assign pc = 64'(tb) * 64'(cd1);

  always_ff @(posedge clk) begin
    if (en) begin
      x2 <= x1;
      t2 <= t1;
      t3 <= pc[61:30];
      z2 <= z1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3 <= 33'(x2);
      y3 <= 33'(t2) - 33'(t3);
      z3 <= z2 || ((x2 == '0) && (t2 == t3));
    end
  end

  gcb_atan2 #(.STEPS(CORDIC_STEPS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_atan2 (
    .clk(clk), .en(en), .num(x3), .den(y3), .zero(z3), .bearing(bearing));

  `GCB_ASSERT_IMP(a_stall_back, m_tvalid && !m_tready, !s_tready, "stall not passed upstream")
  `GCB_ASSERT_NXT(a_entry_valid, s_tvalid && s_tready, vld[0], "accepted item lost at entry")
  `GCB_ASSERT_IMP(a_bear_range, m_tvalid, m_tdata[18:0] != 19'h40000, "bearing out of range")

endmodule
